@@ design/circular_next_free_slot_allocator_unit_defines.svh @@
// Assertion helpers shared by the allocator checker.
`ifndef CIRCULAR_NEXT_FREE_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`define CIRCULAR_NEXT_FREE_SLOT_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CNFSA_AST_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CNFSA_AST_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/cnfsa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cnfsa_pkg;

    // Default slot capacity
    localparam int MAX_SLOTS_DEF = 256;

    // Fixed field widths
    localparam int SLOT_W   = 9;
    localparam int STREAM_W = 16;
    localparam int APB_W    = 32;

    // Occupancy memory row: one bit per slot
    localparam int WORD_W = 32;
    localparam int LOG_W  = 5;

    // Register map
    localparam int ADDR_W = 3;
    localparam logic REG_SLOT_COUNT_SEL = 1'b0;
    localparam logic [SLOT_W-1:0] SLOT_COUNT_RST = 9'd256;

    // Commands
    localparam logic CMD_CLAIM   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } t_state;

endpackage

`default_nettype wire

@@ design/circular_next_free_slot_allocator_unit.sv @@
// Circular slot allocator. Occupancy of up to MAX_SLOTS slots sits in a
// synchronous memory of 32-bit rows, one bit per slot, all free after reset
// (row valid bits stand in for a clearing pass, so no start-up delay). A
// claim (tuser 0) scans rows from the preferred slot upward, then wraps to
// row 0, and returns the first free slot in tdata, marking it occupied; if
// none is free it returns slot 0 with tuser 1. A release (tuser 1) frees the
// named slot and returns 0. One item is worked at a time, each row visit
// taking a read state (ST_READ) and an evaluate state (ST_EVAL): a release
// or a claim that hits in its first row goes from accept through ST_READ
// and ST_EVAL into the output register, and each further row adds another
// ST_READ and ST_EVAL visit, until at worst the scan has wrapped through
// every row. A result waiting in the output register does not block the next accept.
`timescale 1ns / 1ps
`default_nettype none

module circular_next_free_slot_allocator_unit
    import cnfsa_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [APB_W-1:0]    pwdata,
    output logic [APB_W-1:0]    prdata,
    output logic                pready,
    // request stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [STREAM_W-1:0] s_axis_tdata,  // [8:0] slot
    input  logic                s_axis_tuser,  // [0] command
    // result stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [STREAM_W-1:0] m_axis_tdata,  // [8:0] given_slot
    output logic                m_axis_tuser   // [0] full_res
);

    localparam int ROWS  = (MAX_SLOTS + WORD_W - 1) / WORD_W;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    // registers
    t_state              r_state,     n_state;
    logic [SLOT_W-1:0]   r_slot_count;
    logic                r_cmd,       n_cmd;
    logic                r_skip,      n_skip;
    logic                r_phase_b,   n_phase_b;
    logic [ROW_W-1:0]    r_row,       n_row;
    logic [ROW_W-1:0]    r_start_row, n_start_row;
    logic [LOG_W-1:0]    r_off,       n_off;
    logic [CNT_W-1:0]    r_n,         n_n;
    logic                r_out_valid, n_out_valid;
    logic [SLOT_W-1:0]   r_out_slot,  n_out_slot;
    logic                r_out_full,  n_out_full;

    // occupancy memory
    logic [WORD_W-1:0]   r_mem [ROWS];
    logic                r_vld [ROWS];
    logic [WORD_W-1:0]   r_rdata;
    logic                r_row_ok;

    logic                mem_we;
    logic [WORD_W-1:0]   mem_wdata;

    // datapath
    logic                cfg_wr;
    logic                in_acc;
    logic [31:0]         cnt32;
    logic [31:0]         n32;
    logic [31:0]         s32;
    logic [31:0]         idx32;
    logic                in_range;
    logic [ROW_W-1:0]    last_row;
    logic [WORD_W-1:0]   row_data;
    logic [WORD_W-1:0]   avail;
    logic                hit;
    logic [LOG_W-1:0]    k_sel;
    logic                done_ok;

    // configuration access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_SLOT_COUNT_SEL);
    assign prdata = (paddr[ADDR_W-1] == REG_SLOT_COUNT_SEL) ?
                    APB_W'(r_slot_count) : '0;

    // handshake
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign done_ok       = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = STREAM_W'(r_out_slot);
    assign m_axis_tuser  = r_out_full;

    // clamp slot count and decode the requested slot
    always_comb begin
        cnt32 = 32'(r_slot_count);
        if (cnt32 == 32'd0) begin
            n32 = 32'd1;
        end else if (cnt32 > 32'(MAX_SLOTS)) begin
            n32 = 32'(MAX_SLOTS);
        end else begin
            n32 = cnt32;
        end
        s32      = 32'(s_axis_tdata[SLOT_W-1:0]);
        in_range = (s32 != 32'd0) && (s32 <= n32);
        idx32    = s32 - 32'd1;
    end

    assign last_row = ROW_W'((32'(r_n) - 32'd1) >> LOG_W);

    // mask the fetched row and find its lowest free slot
    assign row_data = r_row_ok ? r_rdata : '0;

    always_comb begin
        for (int k = 0; k < WORD_W; k++) begin
            avail[k] = !row_data[k]
                && (((32'(r_row) << LOG_W) + 32'(k)) < 32'(r_n))
                && (r_phase_b || (r_row != r_start_row) || (LOG_W'(k) >= r_off));
        end
        hit   = |avail;
        k_sel = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (avail[k]) begin
                k_sel = LOG_W'(k);
            end
        end
    end

    // sequencer: read a row, evaluate it, write back when a claim hits or an in-range release completes
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_skip      = r_skip;
        n_phase_b   = r_phase_b;
        n_row       = r_row;
        n_start_row = r_start_row;
        n_off       = r_off;
        n_n         = r_n;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_slot  = r_out_slot;
        n_out_full  = r_out_full;
        mem_we      = 1'b0;
        mem_wdata   = row_data;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_READ;
                    n_cmd   = s_axis_tuser;
                    n_n     = CNT_W'(n32);
                    n_skip  = !in_range;
                    if (in_range) begin
                        n_row       = ROW_W'(idx32 >> LOG_W);
                        n_start_row = ROW_W'(idx32 >> LOG_W);
                        n_off       = idx32[LOG_W-1:0];
                        n_phase_b   = 1'b0;
                    end else begin
                        n_row       = '0;
                        n_start_row = '0;
                        n_off       = '0;
                        n_phase_b   = 1'b1;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (r_cmd == CMD_RELEASE) begin
                    if (done_ok) begin
                        mem_we      = !r_skip;
                        mem_wdata   = row_data & ~(WORD_W'(1) << r_off);
                        n_out_valid = 1'b1;
                        n_out_slot  = '0;
                        n_out_full  = 1'b0;
                        n_state     = ST_IDLE;
                    end
                end else if (hit) begin
                    if (done_ok) begin
                        mem_we      = 1'b1;
                        mem_wdata   = row_data | (WORD_W'(1) << k_sel);
                        n_out_valid = 1'b1;
                        n_out_slot  = SLOT_W'((32'(r_row) << LOG_W) + 32'(k_sel) + 32'd1);
                        n_out_full  = 1'b0;
                        n_state     = ST_IDLE;
                    end
                end else if (r_row != last_row) begin
                    n_row   = r_row + ROW_W'(1);
                    n_state = ST_READ;
                end else if (!r_phase_b) begin
                    // wrap to the lowest slot
                    n_phase_b = 1'b1;
                    n_row     = '0;
                    n_state   = ST_READ;
                end else if (done_ok) begin
                    n_out_valid = 1'b1;
                    n_out_slot  = '0;
                    n_out_full  = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_slot_count <= SLOT_COUNT_RST;
            r_out_valid  <= 1'b0;
            r_cmd        <= CMD_CLAIM;
            r_skip       <= 1'b0;
            r_phase_b    <= 1'b0;
            r_row        <= '0;
            r_start_row  <= '0;
            r_off        <= '0;
            r_n          <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cmd       <= n_cmd;
            r_skip      <= n_skip;
            r_phase_b   <= n_phase_b;
            r_row       <= n_row;
            r_start_row <= n_start_row;
            r_off       <= n_off;
            r_n         <= n_n;
            if (cfg_wr) begin
                r_slot_count <= pwdata[SLOT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_slot <= n_out_slot;
        r_out_full <= n_out_full;
    end

    // row valid bits: an unwritten row reads as all free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_vld[r] <= 1'b0;
            end
        end else if (mem_we) begin
            r_vld[r_row] <= 1'b1;
        end
    end

    // occupancy memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_row] <= mem_wdata;
        end
        r_rdata  <= r_mem[r_row];
        r_row_ok <= r_vld[r_row] && i_rst_n;
    end

endmodule

`default_nettype wire

@@ design/cnfsa_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "circular_next_free_slot_allocator_unit_defines.svh"

module cnfsa_chk
    import cnfsa_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                psel,
    input logic                penable,
    input logic                pwrite,
    input logic [ADDR_W-1:0]   paddr,
    input logic [APB_W-1:0]    pwdata,
    input logic [APB_W-1:0]    prdata,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [STREAM_W-1:0] m_axis_tdata,
    input logic                m_axis_tuser
);

    // Hold a stalled result transaction
    `CNFSA_AST_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // A full claim gives no slot
    `CNFSA_AST_IMP(a_full_no_slot, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "full result carries a slot")

    // Keep pad bits of the result clear
    `CNFSA_AST_IMP(a_out_pad, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[STREAM_W-1:SLOT_W] == '0, "result pad bits set")

    // Read back the slot count just written
    `CNFSA_AST_NXT(a_cfg_readback, i_clk, i_rst_n, psel && penable && pwrite && (paddr == '0), (paddr != '0) || (prdata[SLOT_W-1:0] == $past(pwdata[SLOT_W-1:0])), "slot count readback mismatch")

endmodule

bind circular_next_free_slot_allocator_unit cnfsa_chk u_cnfsa_chk (.*);

`default_nettype wire

@@ verif/circular_next_free_slot_allocator_unit_tb.sv @@
`timescale 1ns / 1ps

module circular_next_free_slot_allocator_unit_tb;
    import cnfsa_pkg::*;

    localparam int SLOT_CAP         = MAX_SLOTS_DEF;
    localparam logic [ADDR_W-1:0] ADDR_SLOT_COUNT = 3'd0;
    localparam int SETTLE_CYCLES    = 40;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT      = 3000;
    localparam int ITEMS_PER_PHASE  = 100;
    localparam int PHASES           = 12;

    typedef enum logic {
        ROW_ITEM,
        ROW_SETUP
    } row_kind_e;

    // One line of the directed plan; for ROW_SETUP, slot holds the count to write
    typedef struct packed {
        row_kind_e         kind;
        logic              cmd;
        logic [SLOT_W-1:0] slot;
        logic              typed;
        logic [SLOT_W-1:0] given;
        logic              full;
    } plan_row_t;

    typedef struct packed {
        logic [SLOT_W-1:0] given;
        logic              full;
    } grant_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [APB_W-1:0]    pwdata;
    logic [APB_W-1:0]    prdata;
    logic                pready;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [STREAM_W-1:0] s_axis_tdata;   // [8:0] slot
    logic                s_axis_tuser;   // [0] command
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [STREAM_W-1:0] m_axis_tdata;   // [8:0] given_slot
    logic                m_axis_tuser;   // [0] full_res

    // Side data riding with the current request: a hand-typed expected grant
    logic                req_typed;
    logic [SLOT_W-1:0]   req_given;
    logic                req_full;

    // Allocator mirror
    logic                slot_busy [SLOT_CAP];
    logic [SLOT_W-1:0]   slot_limit;
    grant_t              grant_q [$];

    bit                  sink_hold_req;
    bit                  no_idle;
    int                  mismatches;
    int                  idle_cycles;
    plan_row_t           plan_q [$];

    grant_t              want;
    logic [SLOT_W-1:0]   mon_given;
    logic                mon_full;

    circular_next_free_slot_allocator_unit #(
        .MAX_SLOTS(SLOT_CAP)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Clamp the register to the slot range the allocator actually uses
    function automatic int active_slots();
        if (slot_limit == 0)
            return 1;
        if (slot_limit > SLOT_CAP)
            return SLOT_CAP;
        return int'(slot_limit);
    endfunction

    // Apply one request to the mirror and return the grant it should produce
    task automatic compute_grant(input logic cmd, input logic [SLOT_W-1:0] slot,
                                 output logic [SLOT_W-1:0] given, output logic full);
        int n;
        int hit;
        n = active_slots();
        hit = -1;
        given = '0;
        full = 1'b0;
        if (cmd == CMD_RELEASE) begin
            if (slot >= 1 && slot <= n)
                slot_busy[slot - 1] = 1'b0;
        end else begin
            // search upward from the preferred slot, then wrap to the bottom
            if (slot >= 1 && slot <= n) begin
                for (int k = int'(slot) - 1; k < n && hit < 0; k++)
                    if (!slot_busy[k])
                        hit = k;
            end
            for (int k = 0; k < n && hit < 0; k++)
                if (!slot_busy[k])
                    hit = k;
            if (hit < 0) begin
                full = 1'b1;
            end else begin
                slot_busy[hit] = 1'b1;
                given = SLOT_W'(hit + 1);
            end
        end
    endtask

    // Check results against the oldest expectation, then record new requests and slot count writes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (grant_q.size() == 0) begin
                    $error("unexpected result: given_slot %0d full_res %0b",
                           m_axis_tdata[SLOT_W-1:0], m_axis_tuser);
                    mismatches++;
                end else begin
                    want = grant_q.pop_front();
                    if (m_axis_tdata[SLOT_W-1:0] !== want.given) begin
                        $error("given_slot: expected %0d, got %0d",
                               want.given, m_axis_tdata[SLOT_W-1:0]);
                        mismatches++;
                    end
                    if (m_axis_tuser !== want.full) begin
                        $error("full_res: expected %0b, got %0b", want.full, m_axis_tuser);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                compute_grant(s_axis_tuser, s_axis_tdata[SLOT_W-1:0], mon_given, mon_full);
                if (req_typed) begin
                    mon_given = req_given;
                    mon_full = req_full;
                end
                grant_q.insert(grant_q.size(), grant_t'{given: mon_given, full: mon_full});
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_SLOT_COUNT)
                slot_limit = pwdata[SLOT_W-1:0];
        end
    end

    // Abort if no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("circular_next_free_slot_allocator_unit: mismatch");
            $finish;
        end
    end

    // Result sink: random ready bursts, ready held high in no-idle phases, or a long hold-off on request
    initial begin : result_sink
        int run;
        bit lvl;
        @(negedge i_clk);
        while (!i_rst_n)
            @(negedge i_clk);
        forever begin
            if (sink_hold_req) begin
                m_axis_tready = 1'b0;
                repeat (SINK_HOLD_CYCLES) @(negedge i_clk);
                sink_hold_req = 1'b0;
            end else if (no_idle) begin
                m_axis_tready = 1'b1;
                @(negedge i_clk);
            end else begin
                lvl = ($urandom_range(99) < 70);
                if (lvl)
                    run = $urandom_range(16, 1);
                else if ($urandom_range(9) == 0)
                    run = $urandom_range(40, 10);
                else
                    run = $urandom_range(3, 1);
                m_axis_tready = lvl;
                repeat (run) @(negedge i_clk);
            end
        end
    end

    // Offer one request after a random gap; return at the accepting edge
    task automatic send_item(input logic cmd, input logic [SLOT_W-1:0] slot,
                             input logic typed, input logic [SLOT_W-1:0] given,
                             input logic full);
        int gap;
        if (no_idle || $urandom_range(9) < 6)
            gap = 0;
        else if ($urandom_range(9) == 0)
            gap = $urandom_range(40, 10);
        else
            gap = $urandom_range(3, 1);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = '0;
        s_axis_tdata[SLOT_W-1:0] = slot;
        s_axis_tuser = cmd;
        req_typed = typed;
        req_given = given;
        req_full = full;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // Stop offering and let every outstanding grant come back
    task automatic wait_for_grants();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (grant_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_slot_count(input logic [SLOT_W-1:0] value);
        wait_for_grants();
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = ADDR_SLOT_COUNT;
        pwdata = $urandom();
        pwdata[SLOT_W-1:0] = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic plan(input row_kind_e kind, input logic cmd, input logic [SLOT_W-1:0] slot,
                        input logic typed, input logic [SLOT_W-1:0] given, input logic full);
        plan_q.insert(plan_q.size(), plan_row_t'{kind: kind, cmd: cmd, slot: slot,
                                                 typed: typed, given: given, full: full});
    endtask

    initial begin : stimulus
        plan_row_t         row;
        int                n;
        int                claim_pct;
        int                r;
        int                start;
        int                hit;
        logic              cmd;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] count;

        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_CLAIM;
        m_axis_tready = 1'b0;
        req_typed = 1'b0;
        req_given = '0;
        req_full = 1'b0;
        sink_hold_req = 1'b0;
        no_idle = 1'b0;
        mismatches = 0;
        slot_limit = SLOT_COUNT_RST;
        for (int k = 0; k < SLOT_CAP; k++)
            slot_busy[k] = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fresh allocator: top and bottom slots, wrap-around, out-of-range names
        plan(ROW_ITEM,  CMD_CLAIM,   9'd1,   1'b1, 9'd1,   1'b0);
        plan(ROW_ITEM,  CMD_CLAIM,   9'd1,   1'b1, 9'd2,   1'b0);
        plan(ROW_ITEM,  CMD_CLAIM,   9'd256, 1'b1, 9'd256, 1'b0);
        plan(ROW_ITEM,  CMD_CLAIM,   9'd256, 1'b1, 9'd3,   1'b0);
        plan(ROW_ITEM,  CMD_CLAIM,   9'd0,   1'b1, 9'd4,   1'b0);
        plan(ROW_ITEM,  CMD_CLAIM,   9'd511, 1'b1, 9'd5,   1'b0);
        plan(ROW_ITEM,  CMD_RELEASE, 9'd0,   1'b1, 9'd0,   1'b0);
        plan(ROW_ITEM,  CMD_RELEASE, 9'd511, 1'b1, 9'd0,   1'b0);
        plan(ROW_ITEM,  CMD_RELEASE, 9'd2,   1'b1, 9'd0,   1'b0);
        plan(ROW_ITEM,  CMD_RELEASE, 9'd2,   1'b1, 9'd0,   1'b0);
        plan(ROW_ITEM,  CMD_CLAIM,   9'd1,   1'b1, 9'd2,   1'b0);
        plan(ROW_ITEM,  CMD_RELEASE, 9'd256, 1'b1, 9'd0,   1'b0);
        plan(ROW_ITEM,  CMD_CLAIM,   9'd255, 1'b1, 9'd255, 1'b0);
        plan(ROW_ITEM,  CMD_CLAIM,   9'd255, 1'b1, 9'd256, 1'b0);
        // Single slot: full allocator, out-of-range claim
        plan(ROW_SETUP, CMD_CLAIM,   9'd1,   1'b0, 9'd0,   1'b0);
        plan(ROW_ITEM,  CMD_CLAIM,   9'd1,   1'b1, 9'd0,   1'b1);
        plan(ROW_ITEM,  CMD_RELEASE, 9'd1,   1'b1, 9'd0,   1'b0);
        plan(ROW_ITEM,  CMD_CLAIM,   9'd7,   1'b1, 9'd1,   1'b0);
        plan(ROW_ITEM,  CMD_CLAIM,   9'd0,   1'b1, 9'd0,   1'b1);
        // Zero count behaves as one slot
        plan(ROW_SETUP, CMD_CLAIM,   9'd0,   1'b0, 9'd0,   1'b0);
        plan(ROW_ITEM,  CMD_RELEASE, 9'd1,   1'b1, 9'd0,   1'b0);
        plan(ROW_ITEM,  CMD_CLAIM,   9'd1,   1'b1, 9'd1,   1'b0);
        plan(ROW_ITEM,  CMD_CLAIM,   9'd1,   1'b1, 9'd0,   1'b1);
        // Oversized count clamps to capacity; upper slots kept their bits
        plan(ROW_SETUP, CMD_CLAIM,   9'd300, 1'b0, 9'd0,   1'b0);
        plan(ROW_ITEM,  CMD_CLAIM,   9'd300, 1'b1, 9'd6,   1'b0);
        plan(ROW_ITEM,  CMD_CLAIM,   9'd200, 1'b0, 9'd0,   1'b0);
        plan(ROW_ITEM,  CMD_RELEASE, 9'd6,   1'b1, 9'd0,   1'b0);
        // Two slots, both held
        plan(ROW_SETUP, CMD_CLAIM,   9'd2,   1'b0, 9'd0,   1'b0);
        plan(ROW_ITEM,  CMD_CLAIM,   9'd2,   1'b1, 9'd0,   1'b1);
        plan(ROW_ITEM,  CMD_RELEASE, 9'd2,   1'b1, 9'd0,   1'b0);

        foreach (plan_q[j]) begin
            row = plan_q[j];
            if (row.kind == ROW_SETUP)
                write_slot_count(row.slot);
            else
                send_item(row.cmd, row.slot, row.typed, row.given, row.full);
        end

        // Random phases, each under its own slot count and claim mix
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       count = 9'd1;
                1:       count = 9'd256;
                2:       count = 9'd0;
                3:       count = 9'd2;
                4:       count = 9'd511;
                5:       count = SLOT_W'($urandom_range(16, 3));
                6:       count = 9'd300;
                7:       count = SLOT_W'($urandom_range(64, 17));
                8:       count = SLOT_W'($urandom_range(255, 65));
                9:       count = 9'd256;
                10:      count = 9'd8;
                default: count = SLOT_W'($urandom_range(40, 1));
            endcase
            write_slot_count(count);
            no_idle = ($urandom_range(3) == 0);
            claim_pct = $urandom_range(90, 45);
            n = active_slots();
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                r = $urandom_range(99);
                if ($urandom_range(99) < claim_pct) begin
                    cmd = CMD_CLAIM;
                    if (r < 80)
                        slot = SLOT_W'($urandom_range(n, 1));
                    else if (r < 90)
                        slot = '0;
                    else
                        slot = SLOT_W'($urandom_range(511, n + 1));
                end else begin
                    cmd = CMD_RELEASE;
                    if (r < 60) begin
                        // aim at a held slot so releases do real work
                        slot = SLOT_W'($urandom_range(n, 1));
                        start = $urandom_range(n - 1, 0);
                        hit = 0;
                        for (int k = 0; k < n && !hit; k++) begin
                            if (slot_busy[(start + k) % n]) begin
                                slot = SLOT_W'((start + k) % n + 1);
                                hit = 1;
                            end
                        end
                    end else if (r < 85) begin
                        slot = SLOT_W'($urandom_range(n, 1));
                    end else if (r < 92) begin
                        slot = '0;
                    end else begin
                        slot = SLOT_W'($urandom_range(511, n + 1));
                    end
                end
                send_item(cmd, slot, 1'b0, '0, 1'b0);
                // Back-pressure: stall the sink while requests keep coming
                if (p == 9 && i == ITEMS_PER_PHASE / 2)
                    sink_hold_req = 1'b1;
                // Pause the source until every grant is back
                if (p == 7 && i == ITEMS_PER_PHASE / 2)
                    wait_for_grants();
            end
        end

        wait_for_grants();
        if (mismatches == 0) begin
            $display("circular_next_free_slot_allocator_unit: match");
        end else begin
            $display("circular_next_free_slot_allocator_unit: mismatch");
        end
        $finish;
    end

endmodule
